/* rtl/pfd_pkg.sv */
// Package for the Playfair digraph encryptor: payload structs, square geometry,
// register indexes, reset values and the square lookup functions.
// Depends on nothing; every other file imports it.
package pfd_pkg;

   localparam int LetterBits = 5;
   localparam int NumRows    = 5;
   localparam int NumCols    = 5;
   localparam int RowBits    = LetterBits * NumCols;

   typedef logic [LetterBits-1:0] letter_type;
   typedef logic [NumRows-1:0][RowBits-1:0] square_type;
   typedef logic [2:0] pos_type;

   typedef struct packed {
      logic    found;
      pos_type row;
      pos_type col;
   } locate_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      letter_type cipher_first;
      letter_type cipher_second;
      logic       last_pair;
   } rsp_type;

   // One queued digraph; dup marks a digraph that goes out twice, first unmarked
   // and then marked last.
   typedef struct packed {
      rsp_type rsp;
      logic    dup;
   } rsp_entry_type;

   typedef logic [2:0]         csr_index_type;
   typedef logic [RowBits-1:0] csr_data_type;

   localparam csr_index_type CsrSquareRow0 = 3'd0;
   localparam csr_index_type CsrSquareRow1 = 3'd1;
   localparam csr_index_type CsrSquareRow2 = 3'd2;
   localparam csr_index_type CsrSquareRow3 = 3'd3;
   localparam csr_index_type CsrSquareRow4 = 3'd4;
   localparam csr_index_type CsrFiller     = 3'd5;

   localparam square_type SquareReset = {25'd27025109, 25'd21579246, 25'd14036297,
                                         25'd8624292, 25'd3197954};
   localparam letter_type FillerReset = 5'd23;

   localparam logic [7:0] UpperA = 8'h41;
   localparam logic [7:0] UpperZ = 8'h5A;
   localparam logic [7:0] LowerA = 8'h61;
   localparam logic [7:0] LowerZ = 8'h7A;

   localparam int FifoDepth = 2;

   function automatic letter_type get_cell(square_type sq, pos_type row, pos_type col);
      logic [RowBits-1:0] bits;
      bits = sq[row];
      return bits[col*LetterBits +: LetterBits];
   endfunction

   // The lowest row-major match wins; a miss reports row 0, column 0.
   function automatic locate_type locate(square_type sq, letter_type code);
      locate_type loc;
      loc = '0;
      for (int r = NumRows - 1; r >= 0; r--) begin
         for (int c = NumCols - 1; c >= 0; c--) begin
            if (get_cell(sq, pos_type'(r), pos_type'(c)) == code) begin
               loc.found = 1'b1;
               loc.row   = pos_type'(r);
               loc.col   = pos_type'(c);
            end
         end
      end
      return loc;
   endfunction

endpackage

/* rtl/pfd_cipher.sv */
// Enciphers one digraph with the Playfair rules against the current square.
// Depends on pfd_pkg for the square type and the lookup functions.
module pfd_cipher
   import pfd_pkg::*;
(
   input  square_type sq,
   input  letter_type first_letter,
   input  letter_type second_letter,
   input  logic       last,
   output rsp_type    rsp
);

   locate_type loc_a;
   locate_type loc_b;
   pos_type    col_a_next;
   pos_type    col_b_next;
   pos_type    row_a_next;
   pos_type    row_b_next;

   always_comb begin
      loc_a = locate(sq, first_letter);
      loc_b = locate(sq, second_letter);
      col_a_next = (loc_a.col == pos_type'(NumCols - 1)) ? '0 : loc_a.col + 3'd1;
      col_b_next = (loc_b.col == pos_type'(NumCols - 1)) ? '0 : loc_b.col + 3'd1;
      row_a_next = (loc_a.row == pos_type'(NumRows - 1)) ? '0 : loc_a.row + 3'd1;
      row_b_next = (loc_b.row == pos_type'(NumRows - 1)) ? '0 : loc_b.row + 3'd1;
      rsp.last_pair = last;
      if (loc_a.row == loc_b.row) begin
         rsp.cipher_first  = get_cell(sq, loc_a.row, col_a_next);
         rsp.cipher_second = get_cell(sq, loc_b.row, col_b_next);
      end else if (loc_a.col == loc_b.col) begin
         rsp.cipher_first  = get_cell(sq, row_a_next, loc_a.col);
         rsp.cipher_second = get_cell(sq, row_b_next, loc_b.col);
      end else begin
         rsp.cipher_first  = get_cell(sq, loc_a.row, loc_b.col);
         rsp.cipher_second = get_cell(sq, loc_b.row, loc_a.col);
      end
   end

endmodule

/* rtl/pfd_rsp_fifo.sv */
// Result queue of the Playfair encryptor; an entry marked dup is sent twice.
// Depends on pfd_pkg for the entry and response types.
module pfd_rsp_fifo
   import pfd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  rsp_entry_type push_entry,
   output logic          ready,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data
);

   localparam int PtrBits   = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
   localparam int CountBits = $clog2(FifoDepth + 1);

   rsp_entry_type              mem_ff [FifoDepth];
   logic [PtrBits-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CountBits-1:0]       count_ff, count_in;
   logic                       half_ff, half_in;
   rsp_entry_type              head;
   logic                       send;
   logic                       pop;

   function automatic logic [PtrBits-1:0] ptr_inc(logic [PtrBits-1:0] p);
      return (p == PtrBits'(FifoDepth - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      head      = mem_ff[rd_ptr_ff];
      ready     = (count_ff < CountBits'(FifoDepth));
      rsp_valid = (count_ff != '0);
      rsp_data  = head.rsp;
      if (head.dup && !half_ff) begin
         rsp_data.last_pair = 1'b0;
      end
      send      = rsp_valid && !rsp_stall;
      pop       = send && !(head.dup && !half_ff);
      half_in   = send ? !pop : half_ff;
      wr_ptr_in = push ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CountBits'(push) - CountBits'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         half_ff   <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         half_ff   <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> ready)
      else $error("Result pushed into a full queue.");
   assert property (@(posedge clock) disable iff (reset) count_ff <= CountBits'(FifoDepth))
      else $error("Result queue count exceeds its depth.");
   assert property (@(posedge clock) disable iff (reset) half_ff |-> rsp_valid && head.dup)
      else $error("Repeat flag set without a doubled entry at the head.");

endmodule

/* rtl/playfair_digraph_encryptor.sv */
// Top level of the Playfair digraph encryptor: request register, pairing state,
// configuration registers, cipher logic and result queue.
// Depends on pfd_pkg, pfd_cipher and pfd_rsp_fifo.
//
// The block accepts one text byte per cycle while the result queue has room and
// delivers each digraph from the request register through the single pass
// through square lookup and encipherment that feeds a two-entry result queue. A
// doubled letter on the final byte of a message produces two results from one
// request; these leave one after the other from one queue entry, and the request
// side keeps taking bytes as long as the queue has room. The square and filler
// letter come from the configuration registers; the user must change them only
// while no request is in flight, as the block itself does not enforce this.
module playfair_digraph_encryptor
   import pfd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data,
   input  logic          csr_we,
   input  csr_index_type csr_index,
   input  csr_data_type  csr_wdata
);

   square_type    square_ff, square_in;
   letter_type    filler_ff, filler_in;
   logic          in_valid_ff, in_valid_in;
   req_type       in_req_ff;
   logic          pend_valid_ff, pend_valid_in;
   letter_type    pend_letter_ff, pend_letter_in;

   logic          fifo_ready;
   logic          fire;
   logic          is_letter;
   letter_type    letter;
   locate_type    letter_loc;
   logic          have;
   logic          eom;
   logic          same;
   letter_type    x_letter;
   letter_type    y_letter;
   logic          last0;
   logic          push;
   rsp_type       cipher_rsp;
   rsp_entry_type entry;

   always_comb begin
      square_in = square_ff;
      filler_in = filler_ff;
      if (csr_we) begin
         case (csr_index)
            CsrSquareRow0: square_in[0] = csr_wdata;
            CsrSquareRow1: square_in[1] = csr_wdata;
            CsrSquareRow2: square_in[2] = csr_wdata;
            CsrSquareRow3: square_in[3] = csr_wdata;
            CsrSquareRow4: square_in[4] = csr_wdata;
            CsrFiller:     filler_in    = csr_wdata[LetterBits-1:0];
            default:       ;
         endcase
      end
   end

   always_comb begin
      fire      = in_valid_ff && fifo_ready;
      req_stall = in_valid_ff && !fifo_ready;
      in_valid_in = (req_valid && !req_stall) || (in_valid_ff && !fire);

      is_letter = 1'b0;
      letter    = '0;
      if (in_req_ff.char_code inside {[UpperA:UpperZ]}) begin
         is_letter = 1'b1;
         letter    = letter_type'(in_req_ff.char_code - UpperA);
      end else if (in_req_ff.char_code inside {[LowerA:LowerZ]}) begin
         is_letter = 1'b1;
         letter    = letter_type'(in_req_ff.char_code - LowerA);
      end
      letter_loc = locate(square_ff, letter);
      have = is_letter && letter_loc.found;
      eom  = in_req_ff.end_of_message;
      same = pend_letter_ff == letter;

      x_letter = pend_valid_ff ? pend_letter_ff : letter;
      y_letter = (have && pend_valid_ff && !same) ? letter : filler_ff;
      last0    = eom && !(have && pend_valid_ff && same);
      push     = fire && ((have && (pend_valid_ff || eom)) || (!have && eom && pend_valid_ff));

      entry.rsp = cipher_rsp;
      entry.dup = have && pend_valid_ff && same && eom;
      if (entry.dup) begin
         entry.rsp.last_pair = 1'b1;
      end

      pend_valid_in  = pend_valid_ff;
      pend_letter_in = pend_letter_ff;
      if (fire) begin
         if (eom) begin
            pend_valid_in  = 1'b0;
            pend_letter_in = '0;
         end else if (have) begin
            if (!pend_valid_ff) begin
               pend_valid_in  = 1'b1;
               pend_letter_in = letter;
            end else if (!same) begin
               pend_valid_in = 1'b0;
            end
         end
      end
   end

   pfd_cipher u_cipher (
      .sq            (square_ff),
      .first_letter  (x_letter),
      .second_letter (y_letter),
      .last          (last0),
      .rsp           (cipher_rsp)
   );

   pfd_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (entry),
      .ready      (fifo_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         square_ff      <= SquareReset;
         filler_ff      <= FillerReset;
         in_valid_ff    <= 1'b0;
         pend_valid_ff  <= 1'b0;
         pend_letter_ff <= '0;
      end else begin
         square_ff      <= square_in;
         filler_ff      <= filler_in;
         in_valid_ff    <= in_valid_in;
         pend_valid_ff  <= pend_valid_in;
         pend_letter_ff <= pend_letter_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_req_ff <= req_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset) fire && eom |=> !pend_valid_ff)
      else $error("Letter still pending after end of message.");
   assert property (@(posedge clock) disable iff (reset)
                    fire && have && !pend_valid_ff && !eom |=> pend_valid_ff)
      else $error("Lone letter was not kept pending.");
   assert property (@(posedge clock) disable iff (reset)
                    push && entry.dup |-> eom && pend_valid_ff)
      else $error("Doubled result queued outside end of message.");

endmodule

/* bench/pfd_cipher_checker.sv */
// Checker for the Playfair digraph encryptor: watches the request, result and register ports,
// predicts every enciphered digraph from its own copy of the square and compares in order.
// Depends on pfd_pkg for the payload types, register indexes and reset values.
module pfd_cipher_checker
   import pfd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_stall,
   input  req_type       req_data,
   input  logic          rsp_valid,
   input  logic          rsp_stall,
   input  rsp_type       rsp_data,
   input  logic          csr_we,
   input  csr_index_type csr_index,
   input  csr_data_type  csr_wdata,
   output int            digraphs_owed,
   output int            error_count
);
   timeunit 1ns;
   timeprecision 1ps;

   square_type square_copy;
   letter_type filler_copy;
   letter_type held_letter;
   bit         held_valid;
   rsp_type    cipher_q[$];
   int         mismatches;

   function automatic letter_type cell_at(square_type sq, int row, int col);
      return sq[row][col*LetterBits +: LetterBits];
   endfunction

   function automatic bit find_letter(square_type sq, letter_type code,
                                      output int row, output int col);
      row = 0;
      col = 0;
      for (int r = 0; r < NumRows; r++) begin
         for (int c = 0; c < NumCols; c++) begin
            if (cell_at(sq, r, c) == code) begin
               row = r;
               col = c;
               return 1'b1;
            end
         end
      end
      return 1'b0;
   endfunction

   function automatic rsp_type encipher_pair(square_type sq, letter_type first_letter,
                                             letter_type second_letter, bit last);
      rsp_type pair;
      int r1, c1, r2, c2;
      void'(find_letter(sq, first_letter, r1, c1));
      void'(find_letter(sq, second_letter, r2, c2));
      if (r1 == r2) begin
         pair.cipher_first  = cell_at(sq, r1, (c1 + 1) % NumCols);
         pair.cipher_second = cell_at(sq, r2, (c2 + 1) % NumCols);
      end else if (c1 == c2) begin
         pair.cipher_first  = cell_at(sq, (r1 + 1) % NumRows, c1);
         pair.cipher_second = cell_at(sq, (r2 + 1) % NumRows, c2);
      end else begin
         pair.cipher_first  = cell_at(sq, r1, c2);
         pair.cipher_second = cell_at(sq, r2, c1);
      end
      pair.last_pair = last;
      return pair;
   endfunction

   task automatic queue_pair(rsp_type pair);
      cipher_q.insert(cipher_q.size(), pair);
   endtask

   task automatic encrypt_byte(req_type rq);
      letter_type letter;
      bit         have;
      int         r, c;
      have   = 1'b0;
      letter = '0;
      if (rq.char_code >= UpperA && rq.char_code <= UpperZ) begin
         letter = letter_type'(rq.char_code - UpperA);
         have   = 1'b1;
      end else if (rq.char_code >= LowerA && rq.char_code <= LowerZ) begin
         letter = letter_type'(rq.char_code - LowerA);
         have   = 1'b1;
      end
      if (have && !find_letter(square_copy, letter, r, c))
         have = 1'b0;
      if (have) begin
         if (!held_valid) begin
            held_letter = letter;
            held_valid  = 1'b1;
         end else if (held_letter == letter) begin
            queue_pair(encipher_pair(square_copy, held_letter, filler_copy, 1'b0));
         end else begin
            queue_pair(encipher_pair(square_copy, held_letter, letter,
                                     rq.end_of_message));
            held_valid = 1'b0;
         end
      end
      if (rq.end_of_message && held_valid) begin
         queue_pair(encipher_pair(square_copy, held_letter, filler_copy, 1'b1));
         held_valid = 1'b0;
      end
      if (rq.end_of_message)
         held_letter = '0;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         square_copy = SquareReset;
         filler_copy = FillerReset;
         held_letter = '0;
         held_valid  = 1'b0;
         cipher_q.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CsrFiller)
               filler_copy = csr_wdata[LetterBits-1:0];
            else if (csr_index <= CsrSquareRow4)
               square_copy[csr_index] = csr_wdata;
         end
         if (rsp_valid && !rsp_stall) begin
            if (cipher_q.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: unexpected digraph %0d %0d last %0b", $realtime,
                           rsp_data.cipher_first, rsp_data.cipher_second,
                           rsp_data.last_pair);
               mismatches++;
            end else begin
               want = cipher_q.pop_front();
               if (rsp_data.cipher_first !== want.cipher_first ||
                   rsp_data.cipher_second !== want.cipher_second ||
                   rsp_data.last_pair !== want.last_pair) begin
                  if (mismatches < 10)
                     $display("%0t: mismatch, expected %0d %0d last %0b, got %0d %0d last %0b",
                              $realtime, want.cipher_first, want.cipher_second,
                              want.last_pair, rsp_data.cipher_first,
                              rsp_data.cipher_second, rsp_data.last_pair);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall)
            encrypt_byte(req_data);
      end
      digraphs_owed <= cipher_q.size();
      error_count   <= mismatches;
   end

endmodule

/* bench/tb_playfair_digraph_encryptor.sv */
// Top of the Playfair digraph encryptor testbench: clock, reset, square loading and text stimulus
// with random idling on both channels, plus the watchdog and the verdict.
// Depends on pfd_pkg, playfair_digraph_encryptor and pfd_cipher_checker.
module tb_playfair_digraph_encryptor;
   import pfd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QuietLimit = 5000;

   typedef enum {
      KeepSquare, ShuffledSquare, MissingFiller, WildSquare, ZeroSquare, FullSquare
   } square_plan_type;

   logic          clock     = 1'b0;
   logic          reset     = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   req_type       req_data  = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rsp_type       rsp_data;
   logic          csr_we    = 1'b0;
   csr_index_type csr_index = CsrSquareRow0;
   csr_data_type  csr_wdata = '0;

   int         digraphs_owed;
   int         error_count;
   int         idle_pct    = 0;
   int         stall_pct   = 0;
   int         quiet_count = 0;
   letter_type filler_now  = FillerReset;

   logic [7:0] opening_chars [25] = '{
      "A", "z", 8'h00, 8'hFF, 8'h40, 8'h5B, 8'h60, 8'h7B, "Q", "q", "c", "t", "e",
      "o", "l", "l", "m", "x", "x", "x", 8'h20, "b", 8'h31, "g", "h"};
   bit opening_eom [25] = '{
      0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
      0, 0, 0, 0, 0, 0, 1, 1, 0, 1, 0, 1};

   square_plan_type plan [8] = '{
      KeepSquare, ShuffledSquare, MissingFiller, WildSquare,
      ZeroSquare, FullSquare, ShuffledSquare, WildSquare};
   int plan_items [8] = '{180, 180, 180, 180, 60, 60, 180, 180};

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   playfair_digraph_encryptor i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   pfd_cipher_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .digraphs_owed (digraphs_owed),
      .error_count   (error_count)
   );

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_count <= 0;
      else
         quiet_count <= quiet_count + 1;
   end

   initial begin
      wait (quiet_count >= QuietLimit);
      $display("Simulation FAILED");
      $finish;
   end

   task automatic send_request(logic [7:0] code, bit eom);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid               <= 1'b1;
      req_data.char_code      <= code;
      req_data.end_of_message <= eom;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (digraphs_owed != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type index, csr_data_type value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic load_square(square_type sq, letter_type filler);
      for (int r = 0; r < NumRows; r++)
         write_reg(csr_index_type'(CsrSquareRow0 + r), sq[r]);
      write_reg(CsrFiller, csr_data_type'(filler));
      csr_we     <= 1'b0;
      filler_now = filler;
   endtask

   function automatic square_type shuffled_square(output letter_type left_out);
      letter_type pool [26];
      letter_type swap;
      square_type sq;
      int         j;
      for (int i = 0; i < 26; i++)
         pool[i] = letter_type'(i);
      for (int i = 25; i > 0; i--) begin
         j       = $urandom_range(i);
         swap    = pool[i];
         pool[i] = pool[j];
         pool[j] = swap;
      end
      for (int k = 0; k < 25; k++)
         sq[k / NumCols][(k % NumCols)*LetterBits +: LetterBits] = pool[k];
      left_out = pool[25];
      return sq;
   endfunction

   function automatic logic [7:0] letter_char(letter_type letter);
      return ($urandom_range(1) ? UpperA : LowerA) + 8'(letter);
   endfunction

   initial begin : stimulus
      square_type sq;
      letter_type spare;
      logic [7:0] code;
      logic [7:0] prev_code;
      int         pick;
      prev_code = "a";
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < 25; i++)
         send_request(opening_chars[i], opening_eom[i]);

      for (int b = 0; b < 8; b++) begin
         if (plan[b] != KeepSquare)
            drain_results();
         case (plan[b])
            ShuffledSquare: begin
               sq = shuffled_square(spare);
               load_square(sq, letter_type'($urandom_range(25)));
            end
            MissingFiller: begin
               sq = shuffled_square(spare);
               load_square(sq, spare);
            end
            WildSquare: begin
               sq = {NumRows{25'(0)}};
               for (int k = 0; k < 25; k++)
                  sq[k / NumCols][(k % NumCols)*LetterBits +: LetterBits] =
                     letter_type'($urandom_range(31));
               load_square(sq, letter_type'($urandom_range(25)));
            end
            ZeroSquare: load_square('0, letter_type'(0));
            FullSquare: load_square('1, letter_type'(25));
            default: ;
         endcase
         case (b % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 72; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 72; end
            default: begin idle_pct = 18; stall_pct = 18; end
         endcase
         for (int n = 0; n < plan_items[b]; n++) begin
            pick = $urandom_range(99);
            if (pick < 10)
               code = prev_code;
            else if (pick < 70)
               code = letter_char(letter_type'($urandom_range(25)));
            else if (pick < 78)
               code = letter_char(filler_now);
            else
               code = 8'($urandom_range(255));
            send_request(code, $urandom_range(11) == 0);
            prev_code = code;
         end
      end

      drain_results();
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

/* playfair_digraph_encryptor.f */
rtl/pfd_pkg.sv
rtl/pfd_cipher.sv
rtl/pfd_rsp_fifo.sv
rtl/playfair_digraph_encryptor.sv
bench/pfd_cipher_checker.sv
bench/tb_playfair_digraph_encryptor.sv
